### hdl/salc_pkg.sv
// Shared constants, state encoding and helpers for the set-associative LRU cache.
// No dependencies.
`default_nettype none

package salc_pkg;

  localparam int SETS_DEF           = 64;
  localparam int WAYS_DEF           = 4;
  localparam int WORDS_PER_LINE_DEF = 8;
  localparam int ADDRESS_WIDTH_DEF  = 32;

  localparam int CMD_W  = 1;
  localparam int ADDR_W = 32;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 32;

  localparam logic [CMD_W-1:0] CMD_READ  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESOLVE
  } state_t;

  function automatic int floor_log2(input int v);
    int n;
    int x;
    n = 0;
    x = v;
    while (x > 1) begin
      x = x >> 1;
      n = n + 1;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### hdl/salc_if.sv
// Request and response channel interfaces of the LRU cache.
// Depends on salc_pkg for payload widths.
`default_nettype none

interface salc_req_if;
  import salc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;
  modport source(output valid, command, address, write_data, input ready);
  modport sink(input valid, command, address, write_data, output ready);
endinterface

interface salc_rsp_if;
  import salc_pkg::*;
  logic              valid;
  logic              ready;
  logic              hit;
  logic [DATA_W-1:0] read_data;
  logic [CNT_W-1:0]  read_hit_total;
  logic [CNT_W-1:0]  read_miss_total;
  logic [CNT_W-1:0]  write_hit_total;
  logic [CNT_W-1:0]  write_miss_total;
  modport source(output valid, hit, read_data, read_hit_total, read_miss_total,
                 write_hit_total, write_miss_total, input ready);
  modport sink(input valid, hit, read_data, read_hit_total, read_miss_total,
               write_hit_total, write_miss_total, output ready);
endinterface

`default_nettype wire

### hdl/salc_lru.sv
// Tag match, victim choice and recency-rank update for one set.
// Combinational; depends on salc_pkg only through the house import.
`default_nettype none

module salc_lru #(
  parameter int WAYS  = 4,
  parameter int TAGW  = 23,
  parameter int RANKW = 3,
  parameter int WAYW  = 2
) (
  input  wire logic [WAYS-1:0][TAGW-1:0]  tags,
  input  wire logic [WAYS-1:0][RANKW-1:0] ranks,
  input  wire logic [TAGW-1:0]            tag,
  output logic                            hit,
  output logic [WAYW-1:0]                 victim,
  output logic [WAYS-1:0][RANKW-1:0]      rank_next
);
  import salc_pkg::*;

  logic [WAYS-1:0]  used_map;
  logic [RANKW-1:0] used;
  logic [RANKW-1:0] old_rank;

  always_comb begin
    hit    = 1'b0;
    victim = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (tags[w] == tag) begin
        hit    = 1'b1;
        victim = WAYW'(w);
      end
    end
    if (!hit) begin
      // oldest used way, unless some way was never used
      for (int w = WAYS - 1; w >= 0; w--) begin
        if (ranks[w] == RANKW'(1)) begin
          victim = WAYW'(w);
        end
      end
      for (int w = WAYS - 1; w >= 0; w--) begin
        if (ranks[w] == '0) begin
          victim = WAYW'(w);
        end
      end
    end
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      used_map[w] = (ranks[w] != '0);
    end
    used     = RANKW'($countones(used_map));
    old_rank = ranks[victim];
    for (int w = 0; w < WAYS; w++) begin
      if (WAYW'(w) == victim) begin
        rank_next[w] = (old_rank == '0) ? RANKW'(used + RANKW'(1)) : used;
      end else if (old_rank != '0 && ranks[w] > old_rank) begin
        rank_next[w] = RANKW'(ranks[w] - RANKW'(1));
      end else begin
        rank_next[w] = ranks[w];
      end
    end
  end

endmodule

`default_nettype wire

### hdl/set_assoc_lru_cache.sv
// Set-associative word cache with LRU replacement: memories, control, counters.
// Depends on salc_pkg, salc_if (salc_req_if, salc_rsp_if) and salc_lru.
//
// Usage:
//   req carries one read or write request (command, address, write_data);
//   rsp returns one result per request: hit, read_data and the four running
//   hit/miss totals after that request. Valid/ready on both channels.
//   On accept, a request reads the set's tag/rank entry and the addressed
//   word row from synchronous memory; in the resolve state it picks hit or
//   victim and writes both back. No new request is taken until this
//   read/write-back of the tag and rank memory is done. The result sits in
//   an output register, so a new request is taken while the previous result
//   waits. If rsp is stalled, a request in resolve holds until the output
//   register frees up.
//   After rst (synchronous, active high) all tags, ranks and words are swept
//   to zero, one word row per cycle; req.ready stays low during the sweep.
//   Counters clear at once.
`default_nettype none

module set_assoc_lru_cache #(
  parameter int SETS           = salc_pkg::SETS_DEF,
  parameter int WAYS           = salc_pkg::WAYS_DEF,
  parameter int WORDS_PER_LINE = salc_pkg::WORDS_PER_LINE_DEF,
  parameter int ADDRESS_WIDTH  = salc_pkg::ADDRESS_WIDTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  salc_req_if.sink    req,
  salc_rsp_if.source  rsp
);
  import salc_pkg::*;

  localparam int OB    = floor_log2(WORDS_PER_LINE);
  localparam int IB    = floor_log2(SETS);
  localparam int TAGW  = (ADDRESS_WIDTH > OB + IB) ? ADDRESS_WIDTH - OB - IB : 1;
  localparam int RANKW = $clog2(WAYS + 1);
  localparam int WAYW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SETW  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int ROWS  = SETS * WORDS_PER_LINE;
  localparam int ROWW  = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam logic [ADDR_W-1:0] AMASK   = ADDR_W'((64'd1 << ADDRESS_WIDTH) - 64'd1);
  localparam logic [ADDR_W-1:0] OFFMASK = ADDR_W'((64'd1 << OB) - 64'd1);
  localparam logic [ADDR_W-1:0] SETMASK = ADDR_W'((64'd1 << IB) - 64'd1);

  // memories
  logic [WAYS-1:0][TAGW-1:0]   tag_mem  [SETS];
  logic [WAYS-1:0][RANKW-1:0]  rank_mem [SETS];
  logic [WAYS-1:0][DATA_W-1:0] data_mem [ROWS];

  state_t state, state_next;

  logic [ROWW-1:0] clr_cnt;
  logic            clr_done;

  logic [ADDR_W-1:0] addr_m;
  logic [ADDR_W-1:0] off_a;
  logic [ADDR_W-1:0] set_a;
  logic [ADDR_W-1:0] tag_a;
  logic [SETW-1:0]   in_set;
  logic [ROWW-1:0]   in_row;

  // request held for the resolve cycle
  logic [CMD_W-1:0]  cmd;
  logic [TAGW-1:0]   tag;
  logic [SETW-1:0]   set_idx;
  logic [ROWW-1:0]   row;
  logic [DATA_W-1:0] wdata;

  logic [WAYS-1:0][TAGW-1:0]   tag_rd;
  logic [WAYS-1:0][RANKW-1:0]  rank_rd;
  logic [WAYS-1:0][DATA_W-1:0] row_rd;

  logic                       hit;
  logic [WAYW-1:0]            victim;
  logic [WAYS-1:0][RANKW-1:0] rank_next;
  logic [WAYS-1:0][TAGW-1:0]  tag_next;

  logic req_fire;
  logic res_load;
  logic is_write;

  logic [CNT_W-1:0] rd_hit_cnt, rd_hit_cnt_next;
  logic [CNT_W-1:0] rd_miss_cnt, rd_miss_cnt_next;
  logic [CNT_W-1:0] wr_hit_cnt, wr_hit_cnt_next;
  logic [CNT_W-1:0] wr_miss_cnt, wr_miss_cnt_next;

  // address split
  always_comb begin
    addr_m = req.address & AMASK;
    off_a  = addr_m & OFFMASK;
    set_a  = (addr_m >> OB) & SETMASK;
    tag_a  = addr_m >> (OB + IB);
    in_set = SETW'(set_a);
    in_row = ROWW'(ROWW'(set_a) * ROWW'(WORDS_PER_LINE)) + ROWW'(off_a);
  end

  // control
  assign clr_done = (clr_cnt == ROWW'(ROWS - 1));
  assign req_fire = req.valid && req.ready;
  assign is_write = (cmd == CMD_WRITE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:   if (clr_done) state_next = ST_IDLE;
      ST_IDLE:    if (req.valid) state_next = ST_RESOLVE;
      ST_RESOLVE: if (!rsp.valid || rsp.ready) state_next = ST_IDLE;
      default:    state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    res_load  = 1'b0;
    unique case (state)
      ST_CLEAR:   ;
      ST_IDLE:    req.ready = 1'b1;
      ST_RESOLVE: res_load = !rsp.valid || rsp.ready;
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR && !clr_done) begin
        clr_cnt <= ROWW'(clr_cnt + ROWW'(1));
      end
    end
  end

  // capture the request
  always_ff @(posedge clk) begin
    if (req_fire) begin
      cmd     <= req.command;
      tag     <= TAGW'(tag_a);
      set_idx <= in_set;
      row     <= in_row;
      wdata   <= req.write_data;
    end
  end

  salc_lru #(
    .WAYS  (WAYS),
    .TAGW  (TAGW),
    .RANKW (RANKW),
    .WAYW  (WAYW)
  ) u_lru (
    .tags      (tag_rd),
    .ranks     (rank_rd),
    .tag       (tag),
    .hit       (hit),
    .victim    (victim),
    .rank_next (rank_next)
  );

  always_comb begin
    tag_next         = tag_rd;
    tag_next[victim] = tag;
  end

  // tag and rank memory: cleared by sweep, read on accept, written on resolve
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      if ({1'b0, clr_cnt} < (ROWW + 1)'(SETS)) begin
        tag_mem[SETW'(clr_cnt)]  <= '0;
        rank_mem[SETW'(clr_cnt)] <= '0;
      end
    end else if (res_load) begin
      tag_mem[set_idx]  <= tag_next;
      rank_mem[set_idx] <= rank_next;
    end
    if (req_fire) begin
      tag_rd  <= tag_mem[in_set];
      rank_rd <= rank_mem[in_set];
    end
  end

  // word memory, one row holds the same word of every way
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      data_mem[clr_cnt] <= '0;
    end else if (res_load && is_write) begin
      data_mem[row][victim] <= wdata;
    end
    if (req_fire) begin
      row_rd <= data_mem[in_row];
    end
  end

  // counters
  always_comb begin
    rd_hit_cnt_next  = rd_hit_cnt;
    rd_miss_cnt_next = rd_miss_cnt;
    wr_hit_cnt_next  = wr_hit_cnt;
    wr_miss_cnt_next = wr_miss_cnt;
    if (is_write && hit)        wr_hit_cnt_next  = wr_hit_cnt + CNT_W'(1);
    else if (is_write)          wr_miss_cnt_next = wr_miss_cnt + CNT_W'(1);
    else if (hit)               rd_hit_cnt_next  = rd_hit_cnt + CNT_W'(1);
    else                        rd_miss_cnt_next = rd_miss_cnt + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_hit_cnt  <= '0;
      rd_miss_cnt <= '0;
      wr_hit_cnt  <= '0;
      wr_miss_cnt <= '0;
    end else if (res_load) begin
      rd_hit_cnt  <= rd_hit_cnt_next;
      rd_miss_cnt <= rd_miss_cnt_next;
      wr_hit_cnt  <= wr_hit_cnt_next;
      wr_miss_cnt <= wr_miss_cnt_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      rsp.hit              <= hit;
      rsp.read_data        <= (!is_write && hit) ? row_rd[victim] : '0;
      rsp.read_hit_total   <= rd_hit_cnt_next;
      rsp.read_miss_total  <= rd_miss_cnt_next;
      rsp.write_hit_total  <= wr_hit_cnt_next;
      rsp.write_miss_total <= wr_miss_cnt_next;
    end
  end

`ifndef SYNTH
  a_one_count_per_request: assert property (@(posedge clk) disable iff (rst)
    res_load |=> (rd_hit_cnt + rd_miss_cnt + wr_hit_cnt + wr_miss_cnt) ==
      CNT_W'($past(rd_hit_cnt + rd_miss_cnt + wr_hit_cnt + wr_miss_cnt) + CNT_W'(1)))
    else $error("counters did not advance by exactly one per request");

  a_result_from_resolve: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == ST_RESOLVE)
    else $error("result appeared without a resolved request");

  a_data_needs_hit: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.read_data != '0) |-> rsp.hit)
    else $error("nonzero read data on a miss");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> state == ST_RESOLVE && !req.ready)
    else $error("request accepted while previous one still resolving");
`endif

endmodule

`default_nettype wire
